// ===== src/drt_pkg.sv =====
// Package for the dirty region table: rectangle type, opcodes, table sizes
// and the result type of the shared rectangle compare unit.
// Depends on nothing; every other file imports it.
package drt_pkg;

  localparam int COORD_W     = 16;
  localparam int MAX_REGIONS = 16;
  // Index into the store, and a count that can also hold MAX_REGIONS itself.
  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int TOTAL_W = 5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_REGIONS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_REGIONS);

  typedef enum logic [1:0] {
    OP_MARK   = 2'd0,
    OP_READ   = 2'd1,
    OP_EXTENT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Upper edges (x1, y1) are exclusive.
  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
  } rect_t;

  typedef struct packed {
    logic  covered;  // stored entry encloses the working box
    logic  absorb;   // working box encloses the entry or shares a full edge with it
    rect_t merged;   // bounding union of the two
  } cmp_t;

endpackage

// ===== src/drt_rect_unit.sv =====
// Shared rectangle compare and union unit of the dirty region table.
// Depends on drt_pkg for rect_t and cmp_t.
module drt_rect_unit (
  input  drt_pkg::rect_t cur,
  input  drt_pkg::rect_t entry,
  output drt_pkg::cmp_t  res
);
  import drt_pkg::*;

  logic contains;
  logic h_join;
  logic v_join;

  // When the box holds the entry, or the two share a full edge and touch,
  // the grown box is simply their bounding union.
  always_comb begin
    contains = ($signed(entry.x0) >= $signed(cur.x0)) && ($signed(entry.x1) <= $signed(cur.x1)) &&
               ($signed(entry.y0) >= $signed(cur.y0)) && ($signed(entry.y1) <= $signed(cur.y1));
    h_join   = (cur.y0 == entry.y0) && (cur.y1 == entry.y1) &&
               ($signed(cur.x0) <= $signed(entry.x1)) && ($signed(entry.x0) <= $signed(cur.x1));
    v_join   = (cur.x0 == entry.x0) && (cur.x1 == entry.x1) &&
               ($signed(cur.y0) <= $signed(entry.y1)) && ($signed(entry.y0) <= $signed(cur.y1));

    res.covered = ($signed(cur.x0) >= $signed(entry.x0)) && ($signed(cur.x1) <= $signed(entry.x1)) &&
                  ($signed(cur.y0) >= $signed(entry.y0)) && ($signed(cur.y1) <= $signed(entry.y1));
    res.absorb  = contains || h_join || v_join;

    res.merged.x0 = ($signed(entry.x0) < $signed(cur.x0)) ? entry.x0 : cur.x0;
    res.merged.y0 = ($signed(entry.y0) < $signed(cur.y0)) ? entry.y0 : cur.y0;
    res.merged.x1 = ($signed(entry.x1) > $signed(cur.x1)) ? entry.x1 : cur.x1;
    res.merged.y1 = ($signed(entry.y1) > $signed(cur.y1)) ? entry.y1 : cur.y1;
  end

endmodule

// ===== src/dirty_region_table_top.sv =====
// Top level of the dirty region table: handshake, sequencer, region store.
// Depends on drt_pkg and drt_rect_unit.
//
// The block keeps up to sixteen screen rectangles, each with inclusive top-left
// and exclusive bottom-right edges, and takes one item at a time; in_stall is
// high for as long as an item is being worked on. The region store is a
// single-port memory with a registered read, so every stored entry that a mark
// visits is first fetched and then compared in the one compare and union unit,
// while an extent query streams the entries through it at one a cycle.
// Each entry that a mark absorbs is replaced by moving the last entry into its
// place, after which the scan starts again from the first entry. A finished
// result waits in the output register, and the next transfer on the input side
// is taken while it waits. The store holds no reset value: entries at or above
// the count are never read.
module dirty_region_table_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic signed [15:0]  in_box_x0,
  input  logic signed [15:0]  in_box_y0,
  input  logic signed [15:0]  in_box_x1,
  input  logic signed [15:0]  in_box_y1,
  input  logic [3:0]          in_entry_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_x0,
  output logic signed [15:0]  out_y0,
  output logic signed [15:0]  out_x1,
  output logic signed [15:0]  out_y1,
  output logic                out_already_covered,
  output logic                out_valid_res,
  output logic                out_overflowed,
  output logic [4:0]          out_region_total
);
  import drt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,       // fetch entry at ptr, or finish the scan
    S_SCAN_CMP,   // compare working box against the fetched entry
    S_MOVE,       // write the former last entry into the freed slot
    S_APPEND,     // append, or fetch the last entry when full
    S_OVF,        // union into the last entry
    S_READ_WAIT,
    S_EXT_FIRST,
    S_EXT,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] ptr_r;
  rect_t            cur_r;

  rect_t            res_rect_r;
  logic             res_cov_r;
  logic             res_valid_r;
  logic             res_ovf_r;

  logic             out_valid_r;
  rect_t            out_rect_r;
  logic             out_cov_r;
  logic             out_vres_r;
  logic             out_ovf_r;
  logic [CNT_W-1:0] out_total_r;

  // Region store
  rect_t            mem [MAX_REGIONS];
  rect_t            rd_data_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rect_t            wr_data;

  logic  accept;
  op_t   in_op;
  rect_t in_box;
  logic  box_empty;
  logic  idx_ok;
  logic  ptr_live;
  logic  out_free;
  cmp_t  cmp;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_op     = op_t'(in_opcode);
  assign in_box    = '{x0: in_box_x0, y0: in_box_y0, x1: in_box_x1, y1: in_box_y1};
  assign box_empty = (in_box_x0 >= in_box_x1) || (in_box_y0 >= in_box_y1);
  assign idx_ok    = (32'(in_entry_index) < 32'(count_r));
  assign ptr_live  = (ptr_r < count_r);
  // The output register can take a new result when empty or being emptied.
  assign out_free  = !out_valid_r || !out_stall;

  // The one compare and union unit: working box against the fetched entry.
  drt_rect_unit u_rect (
    .cur   (cur_r),
    .entry (rd_data_r),
    .res   (cmp)
  );

  // Memory port control, decoded from the sequencer state.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = ptr_r[IDX_W-1:0];
    wr_data = cur_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_op == OP_READ) && idx_ok) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(in_entry_index);
        end else if (accept && (in_op == OP_EXTENT) && (count_r != '0)) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      S_SCAN, S_EXT_FIRST, S_EXT: begin
        if (ptr_live) begin
          rd_en   = 1'b1;
          rd_addr = ptr_r[IDX_W-1:0];
        end
      end
      S_SCAN_CMP: begin
        if (!cmp.covered && cmp.absorb) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(count_r - CNT_W'(1));
        end
      end
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[IDX_W-1:0];
        wr_data = rd_data_r;
      end
      S_APPEND: begin
        if (count_r < CNT_MAX) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(count_r);
        end else begin
          rd_en   = 1'b1;
          rd_addr = LAST_IDX;
        end
      end
      S_OVF: begin
        wr_en   = 1'b1;
        wr_addr = LAST_IDX;
        wr_data = cmp.merged;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the output register is refilled instead of emptied.
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_rect_r  <= '0;
            // An empty box is reported covered straight away.
            res_cov_r   <= (in_op == OP_MARK) && box_empty;
            res_valid_r <= 1'b0;
            res_ovf_r   <= 1'b0;
            ptr_r       <= (in_op == OP_EXTENT) ? CNT_W'(1) : '0;
            cur_r       <= in_box;
            case (in_op)
              OP_MARK: begin
                state_r <= box_empty ? S_DONE : S_SCAN;
              end
              OP_READ: begin
                state_r <= idx_ok ? S_READ_WAIT : S_DONE;
              end
              OP_EXTENT: begin
                state_r <= (count_r != '0) ? S_EXT_FIRST : S_DONE;
              end
              OP_CLEAR: begin
                count_r <= '0;
                state_r <= S_DONE;
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN: begin
          state_r <= ptr_live ? S_SCAN_CMP : S_APPEND;
        end

        S_SCAN_CMP: begin
          if (cmp.covered) begin
            // Entries absorbed so far stay removed: their area lies inside this one.
            res_cov_r <= 1'b1;
            state_r   <= S_DONE;
          end else if (cmp.absorb) begin
            cur_r   <= cmp.merged;
            count_r <= count_r - CNT_W'(1);
            state_r <= S_MOVE;
          end else begin
            ptr_r   <= ptr_r + CNT_W'(1);
            state_r <= S_SCAN;
          end
        end

        S_MOVE: begin
          ptr_r   <= '0;
          state_r <= S_SCAN;
        end

        S_APPEND: begin
          if (count_r < CNT_MAX) begin
            count_r <= count_r + CNT_W'(1);
            state_r <= S_DONE;
          end else begin
            state_r <= S_OVF;
          end
        end

        S_OVF: begin
          res_ovf_r <= 1'b1;
          state_r   <= S_DONE;
        end

        S_READ_WAIT: begin
          res_rect_r  <= rd_data_r;
          res_valid_r <= 1'b1;
          state_r     <= S_DONE;
        end

        S_EXT_FIRST: begin
          cur_r <= rd_data_r;
          if (ptr_live) begin
            ptr_r   <= ptr_r + CNT_W'(1);
            state_r <= S_EXT;
          end else begin
            res_rect_r  <= rd_data_r;
            res_valid_r <= 1'b1;
            state_r     <= S_DONE;
          end
        end

        S_EXT: begin
          cur_r <= cmp.merged;
          if (ptr_live) begin
            ptr_r <= ptr_r + CNT_W'(1);
          end else begin
            res_rect_r  <= cmp.merged;
            res_valid_r <= 1'b1;
            state_r     <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_rect_r  <= res_rect_r;
            out_cov_r   <= res_cov_r;
            out_vres_r  <= res_valid_r;
            out_ovf_r   <= res_ovf_r;
            out_total_r <= count_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_x0              = out_rect_r.x0;
  assign out_y0              = out_rect_r.y0;
  assign out_x1              = out_rect_r.x1;
  assign out_y1              = out_rect_r.y1;
  assign out_already_covered = out_cov_r;
  assign out_valid_res       = out_vres_r;
  assign out_overflowed      = out_ovf_r;
  assign out_region_total    = TOTAL_W'(out_total_r);

`ifndef NO_ASSERTIONS
  // The table never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("region count above capacity");

  // A result only appears after the sequencer has finished an item.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result transfer without a finished item");

  // An overflowing mark leaves the table full.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (out_total_r == CNT_MAX))
    else $error("overflow reported on a table that is not full");

  // A mark is either covered or overflowed, never both, and neither carries edges.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_cov_r || out_ovf_r)) |-> (!(out_cov_r && out_ovf_r) && !out_vres_r))
    else $error("conflicting result flags");
`endif

endmodule

// ===== test/dirty_region_table_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the dirty region table top level.
// Depends on drt_pkg and on the RTL of dirty_region_table_top; reads no files.

module dirty_region_table_top_tb;
  import drt_pkg::*;

  // One screen rectangle as the testbench sees it: lower edges inclusive,
  // upper edges exclusive, all four signed.
  typedef struct packed {
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
  } box_t;

  // Everything that one result transfer carries.
  typedef struct packed {
    box_t       edges;
    logic       covered;
    logic       valid_res;
    logic       overflowed;
    logic [4:0] total;
  } table_result_t;

  typedef enum {MARK_APPENDED, MARK_COVERED, MARK_OVERFLOWED} mark_outcome_t;

  // The drain allowance and the settle time after it are sized from the
  // worst correct marking.
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE_TIME  = 700;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_opcode;
  logic signed [15:0] in_box_x0;
  logic signed [15:0] in_box_y0;
  logic signed [15:0] in_box_x1;
  logic signed [15:0] in_box_y1;
  logic [3:0]         in_entry_index;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_x0;
  logic signed [15:0] out_y0;
  logic signed [15:0] out_x1;
  logic signed [15:0] out_y1;
  logic               out_already_covered;
  logic               out_valid_res;
  logic               out_overflowed;
  logic [4:0]         out_region_total;

  // The testbench's own copy of the table, updated at every input transfer.
  box_t model_box [MAX_REGIONS];
  int   model_count = 0;

  // Results still owed by the block, oldest first.
  table_result_t pending_results [$];

  int gap_pct        = 13;
  int stall_pct      = 71;
  int mismatch_count = 0;
  int results_seen   = 0;

  dirty_region_table_top i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A hard stop in case the block hangs and never returns a result.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Small helpers
  // ---------------------------------------------------------------------

  // Uniform integer in [lo, hi]; kept signed so that it mixes safely with
  // negative coordinates in the stimulus arithmetic.
  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic signed [15:0] clamp_coord(int v);
    if (v > 32767)
      return 16'sh7fff;
    if (v < -32768)
      return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic box_t make_box(int x0, int y0, int x1, int y1);
    box_t b;
    b.x0 = clamp_coord(x0);
    b.y0 = clamp_coord(y0);
    b.x1 = clamp_coord(x1);
    b.y1 = clamp_coord(y1);
    return b;
  endfunction

  function automatic box_t rand_box();
    return box_t'({$urandom, $urandom});
  endfunction

  // ---------------------------------------------------------------------
  // Table prediction
  // ---------------------------------------------------------------------

  function automatic bit box_encloses(box_t outer, box_t inner);
    return inner.x0 >= outer.x0 && inner.x1 <= outer.x1 &&
           inner.y0 >= outer.y0 && inner.y1 <= outer.y1;
  endfunction

  // A shared full edge, with the two boxes touching or overlapping along it.
  function automatic bit box_shares_edge(box_t a, box_t b);
    return (a.y0 == b.y0 && a.y1 == b.y1 && a.x0 <= b.x1 && b.x0 <= a.x1) ||
           (a.x0 == b.x0 && a.x1 == b.x1 && a.y0 <= b.y1 && b.y0 <= a.y1);
  endfunction

  function automatic box_t box_hull(box_t a, box_t b);
    box_t u;
    u.x0 = (a.x0 < b.x0) ? a.x0 : b.x0;
    u.y0 = (a.y0 < b.y0) ? a.y0 : b.y0;
    u.x1 = (a.x1 > b.x1) ? a.x1 : b.x1;
    u.y1 = (a.y1 > b.y1) ? a.y1 : b.y1;
    return u;
  endfunction

  // Coalesces one box into the table copy. Whether an entry is contained or
  // joined along an edge, the grown box is simply the bounding union. An
  // absorbed entry is replaced by the last one and the scan starts again.
  function automatic mark_outcome_t model_mark(box_t b);
    box_t grown;
    bit   absorbed;
    grown = b;
    if (b.x0 >= b.x1 || b.y0 >= b.y1)
      return MARK_COVERED;
    do begin
      absorbed = 1'b0;
      for (int i = 0; i < model_count; i++) begin
        if (box_encloses(model_box[i], grown))
          return MARK_COVERED;
        if (box_encloses(grown, model_box[i]) || box_shares_edge(grown, model_box[i])) begin
          grown = box_hull(grown, model_box[i]);
          model_count--;
          model_box[i] = model_box[model_count];
          absorbed = 1'b1;
          break;
        end
      end
    end while (absorbed);
    if (model_count < MAX_REGIONS) begin
      model_box[model_count] = grown;
      model_count++;
      return MARK_APPENDED;
    end
    model_box[MAX_REGIONS-1] = box_hull(model_box[MAX_REGIONS-1], grown);
    return MARK_OVERFLOWED;
  endfunction

  // Applies one input item to the table copy and gives the result it owes.
  function automatic table_result_t table_apply(op_t op, box_t b, logic [3:0] idx);
    table_result_t res;
    mark_outcome_t outcome;
    res = '0;
    case (op)
      OP_MARK: begin
        outcome = model_mark(b);
        res.covered    = (outcome == MARK_COVERED);
        res.overflowed = (outcome == MARK_OVERFLOWED);
      end
      OP_READ: begin
        if (idx < model_count) begin
          res.edges     = model_box[idx];
          res.valid_res = 1'b1;
        end
      end
      OP_EXTENT: begin
        if (model_count > 0) begin
          res.edges = model_box[0];
          for (int i = 1; i < model_count; i++)
            res.edges = box_hull(res.edges, model_box[i]);
          res.valid_res = 1'b1;
        end
      end
      default: begin
        model_count = 0;
      end
    endcase
    res.total = 5'(model_count);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------

  // Presents one item and holds it until the block takes the transfer. Valid
  // is only lowered for a random gap, never between back-to-back transfers,
  // so it receives at most one assignment per time step.
  task automatic send_item(input op_t op, input box_t b, input logic [3:0] idx);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_box_x0      <= b.x0;
    in_box_y0      <= b.y0;
    in_box_x1      <= b.x1;
    in_box_y1      <= b.y1;
    in_entry_index <= idx;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    pending_results.push_back(table_apply(op, b, idx));
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t ns: result %0d, %s: got %0d, expected %0d",
             $time, results_seen, what, got, want);
  endtask

  // The receiver stalls at random; the rate is changed between phases.
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // Every result transfer is compared with the oldest pending expectation.
  // Outputs are read at the edge itself, before the block updates them.
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_x0 !== want.edges.x0)
          report_mismatch("out_x0", out_x0, want.edges.x0);
        if (out_y0 !== want.edges.y0)
          report_mismatch("out_y0", out_y0, want.edges.y0);
        if (out_x1 !== want.edges.x1)
          report_mismatch("out_x1", out_x1, want.edges.x1);
        if (out_y1 !== want.edges.y1)
          report_mismatch("out_y1", out_y1, want.edges.y1);
        if (out_already_covered !== want.covered)
          report_mismatch("out_already_covered", out_already_covered, want.covered);
        if (out_valid_res !== want.valid_res)
          report_mismatch("out_valid_res", out_valid_res, want.valid_res);
        if (out_overflowed !== want.overflowed)
          report_mismatch("out_overflowed", out_overflowed, want.overflowed);
        if (out_region_total !== want.total)
          report_mismatch("out_region_total", out_region_total, want.total);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Queries on an empty table, empty boxes at the coordinate extremes, a box
  // covering the whole plane, a box inside it, and reads in and out of range.
  task automatic test_corner_cases();
    send_item(OP_EXTENT, rand_box(), 4'(rnd(0, 15)));
    send_item(OP_READ, rand_box(), 4'd0);
    send_item(OP_MARK, make_box(32767, 5, 32767, 9), 4'(rnd(0, 15)));
    send_item(OP_MARK, make_box(-32768, 32767, 32767, -32768), 4'(rnd(0, 15)));
    send_item(OP_MARK, make_box(-32768, -32768, 32767, 32767), 4'(rnd(0, 15)));
    send_item(OP_MARK, make_box(-5, -5, 5, 5), 4'(rnd(0, 15)));
    send_item(OP_READ, rand_box(), 4'd0);
    send_item(OP_READ, rand_box(), 4'd15);
  endtask

  // Fills the table with sixteen well separated boxes, overflows it so that
  // the last entry grows over all the others, then marks a box that absorbs
  // the first entry and is found covered by the grown entry moved into its
  // place. The absorbed entry stays gone, so the count drops to fifteen.
  task automatic test_overflow_and_reabsorb();
    send_item(OP_CLEAR, rand_box(), 4'(rnd(0, 15)));
    for (int i = 0; i < MAX_REGIONS; i++)
      send_item(OP_MARK, make_box(i * 10, 0, i * 10 + 2, 2), 4'(rnd(0, 15)));
    send_item(OP_MARK, make_box(0, 100, 1, 101), 4'(rnd(0, 15)));
    send_item(OP_MARK, make_box(0, 0, 2, 3), 4'(rnd(0, 15)));
    send_item(OP_READ, rand_box(), 4'd15);
    send_item(OP_READ, rand_box(), 4'd0);
    send_item(OP_EXTENT, rand_box(), 4'(rnd(0, 15)));
  endtask

  // Well-formed traffic: runs of boxes on a coarse grid around a random
  // origin, so that they often touch, overlap, contain one another or share
  // edges, plus boxes built from a stored entry to force edge joins, full
  // containment and near misses. Reads, extents and the odd clear are mixed
  // in. The origin is sometimes pinned to either end of the coordinate range.
  task automatic test_coalescing_runs(input int n_items);
    int   base_x;
    int   base_y;
    int   run_left;
    int   pick;
    int   r;
    box_t e;
    run_left = 0;
    for (int n = 0; n < n_items; n++) begin
      if (run_left == 0) begin
        case (rnd(0, 9))
          0:       begin base_x = -32768; base_y = rnd(-32768, 32000); end
          1:       begin base_x = rnd(-32768, 32000); base_y = 32767 - 64; end
          default: begin base_x = rnd(-30000, 30000); base_y = rnd(-30000, 30000); end
        endcase
        run_left = rnd(20, 60);
        if (rnd(0, 1) == 0)
          send_item(OP_CLEAR, rand_box(), 4'(rnd(0, 15)));
      end
      run_left--;
      pick = rnd(0, 99);
      if (pick < 45) begin
        r = rnd(0, 15);
        send_item(OP_MARK,
                  make_box(base_x + 4 * r, base_y + 4 * rnd(0, 15),
                           base_x + 4 * (r + rnd(1, 4)), base_y + 4 * rnd(1, 19)),
                  4'(rnd(0, 15)));
      end else if (pick < 72 && model_count > 0) begin
        e = model_box[rnd(0, model_count - 1)];
        r = rnd(0, 2);
        case (rnd(0, 4))
          0: send_item(OP_MARK, make_box(e.x1 - 2 * r, e.y0, e.x1 + 4 * rnd(1, 3), e.y1),
                       4'(rnd(0, 15)));
          1: send_item(OP_MARK, make_box(e.x0 - 4 * rnd(1, 3), e.y0, e.x0 + 2 * r, e.y1),
                       4'(rnd(0, 15)));
          2: send_item(OP_MARK, make_box(e.x0, e.y1 - 2 * r, e.x1, e.y1 + 4 * rnd(1, 3)),
                       4'(rnd(0, 15)));
          3: send_item(OP_MARK, make_box(e.x0 - r, e.y0 - rnd(0, 2), e.x1 + rnd(0, 2), e.y1 + r),
                       4'(rnd(0, 15)));
          default: send_item(OP_MARK,
                             make_box(e.x0 + rnd(0, 1), e.y0, e.x1, e.y1 + rnd(0, 1)),
                             4'(rnd(0, 15)));
        endcase
      end else if (pick < 86) begin
        if (model_count > 0 && rnd(0, 3) != 0)
          send_item(OP_READ, rand_box(), 4'(rnd(0, model_count - 1)));
        else
          send_item(OP_READ, rand_box(), 4'(rnd(0, 15)));
      end else if (pick < 98) begin
        send_item(OP_EXTENT, rand_box(), 4'(rnd(0, 15)));
      end else begin
        send_item(OP_CLEAR, rand_box(), 4'(rnd(0, 15)));
      end
    end
  endtask

  // Unstructured items: every opcode with fully random payload bits, so that
  // each bit of each field sees both values. Clears are thinned out so the
  // table is not emptied too often.
  task automatic test_random_noise(input int n_items);
    op_t op;
    for (int n = 0; n < n_items; n++) begin
      op = op_t'(rnd(0, 3));
      if (op == OP_CLEAR && rnd(0, 3) != 0)
        op = OP_EXTENT;
      send_item(op, rand_box(), 4'(rnd(0, 15)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    int waited;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_MARK;
    in_box_x0      <= '0;
    in_box_y0      <= '0;
    in_box_x1      <= '0;
    in_box_y1      <= '0;
    in_entry_index <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed part runs with a mostly busy sender and a reluctant
    // receiver, which is also the first idling phase.
    test_corner_cases();
    test_overflow_and_reabsorb();

    // Three idling phases: light sender gaps with heavy receiver stalls,
    // then the reverse, then full rate on both sides.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin gap_pct = 13; stall_pct = 71; end
        1:       begin gap_pct = 71; stall_pct = 13; end
        default: begin gap_pct = 0;  stall_pct = 0;  end
      endcase
      test_coalescing_runs(480);
      test_random_noise(170);
    end

    // Drop valid once the last transfer is taken and wait for the block to
    // return everything it owes, then give it time to show any stray result.
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      $display("Regression FAIL");
    end else begin
      repeat (SETTLE_TIME) @(posedge clk);
      if (mismatch_count == 0)
        $display("Regression PASS");
      else
        $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/drt_pkg.sv
src/drt_rect_unit.sv
src/dirty_region_table_top.sv
test/dirty_region_table_top_tb.sv
